// ===== hw/rtl/avcc_pkg.sv =====
// Shared constants for the AVC configuration record to Annex-B converter.
// Parser mode and phase codes, start code and blob length limit.
// No dependencies.
package avcc_pkg;

  localparam logic [15:0] MAX_BLOB_BYTES = 16'hFFFF;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_PASS   = 2'd1;
  localparam logic [1:0] MODE_RECORD = 2'd2;
  localparam logic [1:0] MODE_HALT   = 2'd3;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_COUNT   = 3'd1;
  localparam logic [2:0] PH_LEN_HI  = 3'd2;
  localparam logic [2:0] PH_LEN_LO  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  localparam logic [7:0] HEADER_LAST_POS = 8'd4;
  localparam logic [7:0] SPS_COUNT_MASK  = 8'h1F;
  localparam logic [15:0] MIN_BLOB_BYTES   = 16'd4;
  localparam logic [15:0] MIN_RECORD_BYTES = 16'd7;
  localparam logic [7:0] RECORD_MARKER   = 8'd1;

  localparam logic [2:0] START_CODE_LEN = 3'd4;
  localparam logic [7:0] START_CODE_LAST = 8'h01;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] len_t;

endpackage

// ===== hw/rtl/avcc_if.sv =====
// Valid/ready channel interfaces for the converter's byte input and output.
// Depends on avcc_pkg for payload types.
interface avcc_in_if;
  logic                 valid;
  logic                 ready;
  avcc_pkg::byte_t      data_byte;
  avcc_pkg::len_t       blob_length;
  logic                 blob_start;

  modport source (output valid, data_byte, blob_length, blob_start, input ready);
  modport sink   (input valid, data_byte, blob_length, blob_start, output ready);
endinterface

interface avcc_out_if;
  logic                 valid;
  logic                 ready;
  avcc_pkg::byte_t      out_byte;
  logic                 run_last;

  modport source (output valid, out_byte, run_last, input ready);
  modport sink   (input valid, out_byte, run_last, output ready);
endinterface

// ===== hw/rtl/avcc_to_annexb_converter_core.sv =====
// Top level of the AVC configuration record to Annex-B converter.
// Depends on avcc_pkg and the channel interfaces in avcc_if.sv.
//
// Usage:
//   in_chan carries one extradata byte per transaction with the blob's total
//   length and a blob_start flag on the first byte of each blob.
//   out_chan carries Annex-B bytes; run_last marks the final byte produced by
//   one input byte (single bytes and the 01 of each start code).
//   An accepted byte is registered and appears on out_chan in the cycle after
//   its acceptance. Pass-through and payload bytes flow at one per cycle while
//   out_chan.ready stays high. A unit length byte that opens a unit yields a
//   four-byte start code, holding in_chan.ready low while the register drains.
//   in_chan.ready is high whenever the output register is empty or its last
//   pending byte is taken in the same cycle.
//   When the receiver stalls, the output register holds its byte and the
//   input stalls once the register is full; nothing is dropped.
//   Reset clears the parser to idle and empties the output register; bytes
//   before the first blob_start are ignored.
module avcc_to_annexb_converter_core (
  input  logic       clk,
  input  logic       rst_n,
  avcc_in_if.sink    in_chan,
  avcc_out_if.source out_chan
);
  import avcc_pkg::*;

  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic        round_r, round_nxt;
  logic [7:0]  units_r, units_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] size_r, size_nxt;

  logic [2:0]  rem_r;
  logic        sc_r;
  logic [7:0]  byte_r;

  logic [2:0]  n_v;
  logic        sc_v;
  logic        in_acc;
  logic        out_acc;

  logic [15:0] len_c;
  logic [15:0] p;
  logic [7:0]  b;
  logic [15:0] ulen;
  logic [7:0]  units_dec;
  logic [7:0]  units_dec2;
  logic [15:0] left_dec;

  assign b        = in_chan.data_byte;
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_acc  = out_chan.valid && out_chan.ready;
  assign in_chan.ready = (rem_r == 3'd0) || ((rem_r == 3'd1) && out_chan.ready);

  assign out_chan.valid    = (rem_r != 3'd0);
  assign out_chan.run_last = (rem_r == 3'd1);
  assign out_chan.out_byte = sc_r ? ((rem_r == 3'd1) ? START_CODE_LAST : 8'h00) : byte_r;

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    round_nxt  = round_r;
    units_nxt  = units_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    size_nxt   = size_r;
    n_v        = 3'd0;
    sc_v       = 1'b0;
    len_c      = (in_chan.blob_length > MAX_BLOB_BYTES) ? MAX_BLOB_BYTES
                                                         : in_chan.blob_length;
    p          = 16'd0;
    ulen       = {len_hi_r, b};
    units_dec  = 8'd0;
    units_dec2 = 8'd0;
    left_dec   = 16'd0;

    if (in_chan.blob_start) begin
      size_nxt   = len_c;
      pos_nxt    = 16'd0;
      phase_nxt  = PH_HEADER;
      round_nxt  = 1'b0;
      units_nxt  = 8'd0;
      len_hi_nxt = 8'd0;
      left_nxt   = 16'd0;
      priority if (len_c < MIN_BLOB_BYTES) begin
        mode_nxt = MODE_HALT;
      end else if (b != RECORD_MARKER) begin
        mode_nxt = MODE_PASS;
      end else if (len_c < MIN_RECORD_BYTES) begin
        mode_nxt = MODE_HALT;
      end else begin
        mode_nxt = MODE_RECORD;
      end
    end

    if ((mode_nxt != MODE_IDLE) && (pos_nxt < size_nxt)) begin
      p       = pos_nxt;
      pos_nxt = pos_nxt + 16'd1;
      if (mode_nxt == MODE_PASS) begin
        n_v = 3'd1;
      end else if (mode_nxt == MODE_RECORD) begin
        unique case (phase_nxt)
          PH_HEADER: begin
            if (p >= {8'd0, HEADER_LAST_POS}) begin
              phase_nxt = PH_COUNT;
            end
          end
          PH_COUNT: begin
            units_nxt = round_nxt ? b : (b & SPS_COUNT_MASK);
            priority if (units_nxt != 8'd0) begin
              phase_nxt = PH_LEN_HI;
            end else if (!round_nxt) begin
              round_nxt = 1'b1;
            end else begin
              mode_nxt = MODE_HALT;
            end
          end
          PH_LEN_HI: begin
            if (({1'b0, p} + 17'd2) > {1'b0, size_nxt}) begin
              mode_nxt = MODE_HALT;
            end else begin
              len_hi_nxt = b;
              phase_nxt  = PH_LEN_LO;
            end
          end
          PH_LEN_LO: begin
            if (({2'b0, p} + 18'd1 + {2'b0, ulen}) > {2'b0, size_nxt}) begin
              mode_nxt = MODE_HALT;
            end else begin
              n_v      = START_CODE_LEN;
              sc_v     = 1'b1;
              left_nxt = ulen;
              if (ulen == 16'd0) begin
                units_dec = units_nxt - 8'd1;
                units_nxt = units_dec;
                priority if (units_dec != 8'd0) begin
                  phase_nxt = PH_LEN_HI;
                end else if (!round_nxt) begin
                  round_nxt = 1'b1;
                  phase_nxt = PH_COUNT;
                end else begin
                  mode_nxt = MODE_HALT;
                end
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            n_v      = 3'd1;
            left_dec = left_nxt - 16'd1;
            left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              units_dec2 = units_nxt - 8'd1;
              units_nxt  = units_dec2;
              priority if (units_dec2 != 8'd0) begin
                phase_nxt = PH_LEN_HI;
              end else if (!round_nxt) begin
                round_nxt = 1'b1;
                phase_nxt = PH_COUNT;
              end else begin
                mode_nxt = MODE_HALT;
              end
            end
          end
          default: begin
            mode_nxt = MODE_HALT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= 16'd0;
      phase_r  <= PH_HEADER;
      round_r  <= 1'b0;
      units_r  <= 8'd0;
      len_hi_r <= 8'd0;
      left_r   <= 16'd0;
      size_r   <= 16'd0;
      rem_r    <= 3'd0;
      sc_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r   <= mode_nxt;
        pos_r    <= pos_nxt;
        phase_r  <= phase_nxt;
        round_r  <= round_nxt;
        units_r  <= units_nxt;
        len_hi_r <= len_hi_nxt;
        left_r   <= left_nxt;
        size_r   <= size_nxt;
        rem_r    <= n_v;
        sc_r     <= sc_v;
      end else if (out_acc) begin
        rem_r <= rem_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= b;
    end
  end

`ifndef SYNTHESIS
  a_ready_only_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> (rem_r <= 3'd1))
    else $error("input taken while output register holds several bytes");

  a_idle_has_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (rem_r == 3'd0))
    else $error("output pending before any blob");

  a_pass_single_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_PASS) |-> (!sc_r && (rem_r <= 3'd1)))
    else $error("start code produced in pass-through mode");

  a_start_code_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && sc_v) |=> ((rem_r == START_CODE_LEN) && (out_chan.out_byte == 8'h00)))
    else $error("start code not loaded into output register");
`endif

endmodule

// ===== bench/avcc_to_annexb_converter_core_test.sv =====
// Testbench for avcc_to_annexb_converter_core: directed and random extradata blobs go in
// byte by byte and every Annex-B output byte is checked against a cycle-free predictor.
// Depends on avcc_pkg and the channel interfaces in avcc_if.sv.
module avcc_to_annexb_converter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import avcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 470;

  typedef struct packed {
    byte_t data;
    logic  last;
  } annexb_out_t;

  class annexb_scoreboard;
    logic [1:0]  mode = MODE_IDLE;
    logic [15:0] next_pos = '0;
    logic [2:0]  phase = PH_HEADER;
    logic        pps_round = 1'b0;
    logic [7:0]  units_left = '0;
    logic [7:0]  len_high = '0;
    logic [15:0] payload_left = '0;
    logic [15:0] blob_size = '0;
    annexb_out_t expected_q[$];
    int          errors = 0;
    int          checked = 0;

    function void expect_byte(byte_t d, logic last);
      expected_q.insert(expected_q.size(), annexb_out_t'{d, last});
    endfunction

    function void end_unit();
      units_left = units_left - 8'd1;
      if (units_left != 8'd0) begin
        phase = PH_LEN_HI;
      end else if (!pps_round) begin
        pps_round = 1'b1;
        phase = PH_COUNT;
      end else begin
        mode = MODE_HALT;
      end
    endfunction

    function void note_input(byte_t b, len_t len, logic start);
      logic [15:0] p;
      logic [15:0] unit_len;
      if (start) begin
        blob_size = (len > MAX_BLOB_BYTES) ? MAX_BLOB_BYTES : len;
        next_pos = '0;
        phase = PH_HEADER;
        pps_round = 1'b0;
        units_left = '0;
        len_high = '0;
        payload_left = '0;
        if (blob_size < MIN_BLOB_BYTES) mode = MODE_HALT;
        else if (b != RECORD_MARKER) mode = MODE_PASS;
        else if (blob_size < MIN_RECORD_BYTES) mode = MODE_HALT;
        else mode = MODE_RECORD;
      end
      if (mode == MODE_IDLE || next_pos >= blob_size) return;
      p = next_pos;
      next_pos = next_pos + 16'd1;
      if (mode == MODE_PASS) begin
        expect_byte(b, 1'b1);
        return;
      end
      if (mode != MODE_RECORD) return;
      case (phase)
        PH_HEADER: begin
          if (p >= 16'(HEADER_LAST_POS)) phase = PH_COUNT;
        end
        PH_COUNT: begin
          units_left = pps_round ? b : (b & SPS_COUNT_MASK);
          if (units_left != 8'd0) phase = PH_LEN_HI;
          else if (!pps_round) pps_round = 1'b1;
          else mode = MODE_HALT;
        end
        PH_LEN_HI: begin
          if (32'(p) + 2 > 32'(blob_size)) begin
            mode = MODE_HALT;
          end else begin
            len_high = b;
            phase = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          unit_len = {len_high, b};
          if (32'(p) + 1 + 32'(unit_len) > 32'(blob_size)) begin
            mode = MODE_HALT;
          end else begin
            repeat (3) expect_byte(8'h00, 1'b0);
            expect_byte(START_CODE_LAST, 1'b1);
            payload_left = unit_len;
            if (unit_len == 16'd0) end_unit();
            else phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          expect_byte(b, 1'b1);
          payload_left = payload_left - 16'd1;
          if (payload_left == 16'd0) end_unit();
        end
        default: mode = MODE_HALT;
      endcase
    endfunction

    function void check_output(byte_t b, logic last);
      annexb_out_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output, expected nothing, actual byte %h run_last %b",
                 $time, b, last);
        return;
      end
      want = expected_q.pop_front();
      if (b !== want.data) begin
        errors++;
        $display("%0t: out_byte mismatch, expected %h, actual %h", $time, want.data, b);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: run_last mismatch, expected %b, actual %b", $time, want.last, last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  avcc_in_if  in_chan();
  avcc_out_if out_chan();

  avcc_to_annexb_converter_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  annexb_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int          burst_left = 0;
  int          live_items = 0;
  int          stall_pct = 0;
  int          pattern_left = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: check each transaction, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      sb.check_output(out_chan.out_byte, out_chan.run_last);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else if (!long_hold_done && sb.checked >= 60) begin
      long_hold_done = 1'b1;
      hold_left = 300;
      out_chan.ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 75;
        endcase
      end
      pattern_left--;
      out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_byte(byte_t b, len_t len, logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.blob_length <= len;
    in_chan.blob_start <= start;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_input(b, len, start);
  endtask

  task automatic send_blob(byte_t q[$], len_t len);
    foreach (q[i]) begin
      // blob_length on later bytes is ignored, so scramble it now and then
      send_byte(q[i], (i == 0 || $urandom_range(0, 7) != 0) ? len : 16'($urandom), i == 0);
      if (i < len) live_items++;
    end
  endtask

  function automatic void add_unit(ref byte_t q[$]);
    int ulen;
    ulen = ($urandom_range(0, 39) == 0) ? $urandom_range(64, 260) : $urandom_range(0, 8);
    q.insert(q.size(), 8'(ulen >> 8));
    q.insert(q.size(), 8'(ulen));
    repeat (ulen) q.insert(q.size(), 8'($urandom));
  endfunction

  task automatic run_random_blobs();
    byte_t blob[$];
    len_t  len;
    int    kind;
    int    n_sps;
    int    n_pps;
    while (live_items < RANDOM_ITEMS) begin
      blob.delete();
      kind = $urandom_range(0, 9);
      if (kind <= 5 || kind == 9) begin
        blob.insert(blob.size(), RECORD_MARKER);
        repeat (4) blob.insert(blob.size(), 8'($urandom));
        n_sps = $urandom_range(0, 3);
        blob.insert(blob.size(), {3'($urandom), 5'(n_sps)});
        repeat (n_sps) add_unit(blob);
        n_pps = $urandom_range(0, 2);
        blob.insert(blob.size(), ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(n_pps));
        repeat (n_pps) add_unit(blob);
        repeat ($urandom_range(0, 3)) blob.insert(blob.size(), 8'($urandom));
        len = len_t'(blob.size());
        // cut the declared length to hit truncated length fields and units
        if (kind == 9) len = len_t'($urandom_range(4, blob.size()));
      end else if (kind <= 7) begin
        repeat ($urandom_range(4, 20)) blob.insert(blob.size(), 8'($urandom));
        len = len_t'(blob.size());
      end else begin
        repeat ($urandom_range(1, 12)) blob.insert(blob.size(), 8'($urandom));
        len = 16'($urandom);
      end
      send_blob(blob, len);
    end
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.data_byte = '0;
    in_chan.blob_length = '0;
    in_chan.blob_start = 1'b0;
    out_chan.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // bytes before any blob
    send_byte(RECORD_MARKER, 16'd8, 1'b0);
    send_byte(8'hFF, 16'hFFFF, 1'b0);
    // blob too short for anything
    send_blob('{RECORD_MARKER, 8'h00, 8'h00}, 16'd3);
    // record too short
    send_blob('{RECORD_MARKER, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 16'd6);
    // no SPS, one empty PPS, then a tail byte
    send_blob('{RECORD_MARKER, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE0, 8'h01, 8'h00, 8'h00,
                8'hAA}, 16'd10);
    // pass-through with the largest length
    send_blob('{8'h00, 8'hFF, 8'h7F, 8'h80}, 16'hFFFF);

    live_items = 0;
    run_random_blobs();
    in_chan.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/avcc_pkg.sv
hw/rtl/avcc_if.sv
hw/rtl/avcc_to_annexb_converter_core.sv
bench/avcc_to_annexb_converter_core_test.sv
